FILE: hdl/hsvc_pkg.sv
// Shared types and constants of the HSV hue colour classifier.
`default_nettype none

package hsvc_pkg;

    localparam int unsigned HUE_FRAC_BITS_DEF = 6;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned DIV_BITS_PER_STG  = 4;

    // Hue numerator constants (degrees times chroma).
    localparam logic [16:0] DEG_60  = 17'd60;
    localparam logic [16:0] DEG_120 = 17'd120;
    localparam logic [16:0] DEG_240 = 17'd240;
    localparam logic [16:0] DEG_360 = 17'd360;

    localparam int unsigned SAT_SHIFT = 8;
    localparam logic [8:0]  SAT_GREY  = 9'd256;

    // Class codes.
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_RED   = 2'd1;
    localparam logic [1:0] CLS_BLUE  = 2'd2;
    localparam logic [1:0] CLS_GREEN = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_RED_LOW   = 3'd0;
    localparam logic [2:0] REG_RED_HIGH  = 3'd1;
    localparam logic [2:0] REG_BLUE_LOW  = 3'd2;
    localparam logic [2:0] REG_BLUE_HIGH = 3'd3;
    localparam logic [2:0] REG_GRN_LOW   = 3'd4;
    localparam logic [2:0] REG_GRN_HIGH  = 3'd5;
    localparam logic [2:0] REG_GRN_SAT   = 3'd6;

    typedef struct packed {
        logic [8:0] red_low_limit;
        logic [8:0] red_high_limit;
        logic [8:0] blue_low_limit;
        logic [8:0] blue_high_limit;
        logic [8:0] green_low_limit;
        logic [8:0] green_high_limit;
        logic [8:0] green_sat_floor;
    } cfg_t;

    // One classified pixel waiting for its divisions.
    typedef struct packed {
        logic [31:0] pix_out;
        logic [1:0]  cls;
        logic [7:0]  mx;
        logic [7:0]  chroma;
        logic [16:0] p;
    } q_entry_t;

    typedef struct packed {
        logic [31:0] pix_out;
        logic [1:0]  cls;
        logic [7:0]  mx;
        logic [7:0]  chroma;
    } back_pay_t;

endpackage

`default_nettype wire

FILE: hdl/hsv_hue_color_classifier_core.sv
// Top level of the HSV hue colour classifier: register bank, front, queue, back.
`default_nettype none

// One packed pixel (red 7:0, green 15:8, blue 23:16, alpha 31:24) goes in per
// request on the s_ stream; one result comes out per pixel on the m_ stream, in
// order. Brightness is the largest channel, saturation is chroma*256/max
// (256 for grey or black), hue is in 1/2^HUE_FRAC_BITS degree, truncated, with
// red winning ties, then green. The band tests use the exact hue, so 35.01
// degrees is not "at or below 35". Class order is red band, blue band, then
// green band with saturation strictly above green_sat_floor; an unclassified
// pixel comes out with class 0 and pixel_out zero. A grey pixel has hue 0 and
// lands in the red band with the reset limits.
// Rate: one pixel per clock sustained while m_tready stays high, independent
// of data. The first front stage loads on the accepting edge; after it come
// two more front stages, one queue slot, ceil((9 + HUE_FRAC_BITS) / 4) divider
// stages (4 quotient bits per stage) and the output register. The front and
// back are split by a 4-entry queue, so a stalled m_tready backs up into the
// queue before s_tready drops. Register writes are taken on any cycle (cfg_ready
// is tied high) and must only happen while the block holds no pixels;
// indexes past green_sat_floor are ignored.
module hsv_hue_color_classifier_core #(
    parameter int unsigned HUE_FRAC_BITS = hsvc_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input pixel stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,     // pixel_in[31:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,     // hue[14:0], saturation[23:15],
                                     // brightness[31:24], pixel_out[63:32]
    output logic [1:0]  m_tuser,     // color_class[1:0]
    // register writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [8:0]  cfg_data
);

    hsvc_pkg::cfg_t     cfg_reg;
    logic               q_full, q_push, q_pop, q_not_empty;
    hsvc_pkg::q_entry_t q_in, q_out;

    // Band limits and saturation floor, written by index.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_low_limit    <= 9'd35;
            cfg_reg.red_high_limit   <= 9'd330;
            cfg_reg.blue_low_limit   <= 9'd120;
            cfg_reg.blue_high_limit  <= 9'd320;
            cfg_reg.green_low_limit  <= 9'd50;
            cfg_reg.green_high_limit <= 9'd120;
            cfg_reg.green_sat_floor  <= 9'd153;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hsvc_pkg::REG_RED_LOW:   cfg_reg.red_low_limit    <= cfg_data;
                hsvc_pkg::REG_RED_HIGH:  cfg_reg.red_high_limit   <= cfg_data;
                hsvc_pkg::REG_BLUE_LOW:  cfg_reg.blue_low_limit   <= cfg_data;
                hsvc_pkg::REG_BLUE_HIGH: cfg_reg.blue_high_limit  <= cfg_data;
                hsvc_pkg::REG_GRN_LOW:   cfg_reg.green_low_limit  <= cfg_data;
                hsvc_pkg::REG_GRN_HIGH:  cfg_reg.green_high_limit <= cfg_data;
                hsvc_pkg::REG_GRN_SAT:   cfg_reg.green_sat_floor  <= cfg_data;
                default: ;                                  // unused index
            endcase
        end
    end

    hsvc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    hsvc_queue #(
        .DEPTH (hsvc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_out),
        .not_empty (q_not_empty)
    );

    hsvc_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // An unclassified pixel is always zeroed.
    a_none_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == hsvc_pkg::CLS_NONE) |-> (m_tdata[63:32] == 32'd0))
        else $error("unclassified pixel not zeroed");

    // Black has zero chroma: hue 0 and saturation 256.
    a_black_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:24] == 8'd0)
        |-> (m_tdata[14:0] == 15'd0) && (m_tdata[23:15] == hsvc_pkg::SAT_GREY))
        else $error("black pixel with nonzero hue or partial saturation");

    // Saturation divider never exceeds full scale.
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:15] <= hsvc_pkg::SAT_GREY))
        else $error("saturation above 256");

endmodule

`default_nettype wire

FILE: hdl/hsvc_queue.sv
// Small register FIFO between the classifying front and the divider back end.
`default_nettype none

module hsvc_queue #(
    parameter int unsigned DEPTH = hsvc_pkg::QUEUE_DEPTH
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  wire hsvc_pkg::q_entry_t   din,
    output logic                      full,
    input  wire                       pop,
    output hsvc_pkg::q_entry_t        dout,
    output logic                      not_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    hsvc_pkg::q_entry_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hsvc_front.sv
// Front end: accepts pixels, finds max/chroma/hue numerator and classifies.
`default_nettype none

module hsvc_front (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire hsvc_pkg::cfg_t      cfg,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire  [31:0]              s_tdata,
    input  wire                      q_full,
    output logic                     q_push,
    output hsvc_pkg::q_entry_t       q_entry
);

    logic adv;

    // Stage 1: channel max/min.
    logic        s1_valid_reg;
    logic [31:0] s1_pix_reg;
    logic [7:0]  s1_mx_reg, s1_chroma_reg;
    logic        s1_red_max_reg, s1_grn_max_reg;
    logic [7:0]  r_in, g_in, b_in, mx_next, mn_next;
    logic        red_max_next, grn_max_next;

    // Stage 2: hue numerator and band products.
    logic        s2_valid_reg;
    logic [31:0] s2_pix_reg;
    logic [7:0]  s2_mx_reg, s2_chroma_reg;
    logic [16:0] s2_p_reg, p_next;
    logic [16:0] s2_rl_reg, s2_rh_reg, s2_bl_reg, s2_bh_reg, s2_gl_reg, s2_gh_reg;
    logic [17:0] s2_sat_rhs_reg, sat_rhs_next;
    logic [16:0] r17, g17, b17, c17;

    // Stage 3: class.
    logic               s3_valid_reg;
    hsvc_pkg::q_entry_t s3_entry_reg, entry_next;
    logic               sel_red, sel_blue, sel_grn, sat_gt;
    logic [1:0]         cls_next;

    assign adv      = !s3_valid_reg || !q_full;
    assign s_tready = adv;
    assign q_push   = s3_valid_reg && !q_full;
    assign q_entry  = s3_entry_reg;

    always_comb begin
        r_in = s_tdata[7:0];
        g_in = s_tdata[15:8];
        b_in = s_tdata[23:16];
        red_max_next = (r_in >= g_in) && (r_in >= b_in);
        grn_max_next = !red_max_next && (g_in >= b_in);
        mx_next = red_max_next ? r_in : (grn_max_next ? g_in : b_in);
        if ((r_in <= g_in) && (r_in <= b_in)) begin
            mn_next = r_in;
        end else if (g_in <= b_in) begin
            mn_next = g_in;
        end else begin
            mn_next = b_in;
        end
    end

    always_comb begin
        r17 = 17'(s1_pix_reg[7:0]);
        g17 = 17'(s1_pix_reg[15:8]);
        b17 = 17'(s1_pix_reg[23:16]);
        c17 = 17'(s1_chroma_reg);
        if (s1_red_max_reg) begin
            if (g17 >= b17) begin
                p_next = hsvc_pkg::DEG_60 * (g17 - b17);
            end else begin
                p_next = hsvc_pkg::DEG_360 * c17 - hsvc_pkg::DEG_60 * (b17 - g17);
            end
        end else if (s1_grn_max_reg) begin
            p_next = hsvc_pkg::DEG_120 * c17 + hsvc_pkg::DEG_60 * b17
                   - hsvc_pkg::DEG_60 * r17;
        end else begin
            p_next = hsvc_pkg::DEG_240 * c17 + hsvc_pkg::DEG_60 * r17
                   - hsvc_pkg::DEG_60 * g17;
        end
        // sat > floor  <=>  chroma*256 >= (floor+1)*max
        sat_rhs_next = (18'(cfg.green_sat_floor) + 18'd1) * 18'(s1_mx_reg);
    end

    always_comb begin
        sel_red = (s2_p_reg <= s2_rl_reg) || (s2_p_reg >= s2_rh_reg);
        sel_blue = (s2_p_reg >= s2_bl_reg) && (s2_p_reg <= s2_bh_reg);
        sel_grn = (s2_p_reg >= s2_gl_reg) && (s2_p_reg <= s2_gh_reg);
        if (s2_chroma_reg == '0) begin
            sat_gt = !cfg.green_sat_floor[8];   // grey: saturation reads 256
        end else begin
            sat_gt = ({2'b00, s2_chroma_reg, 8'h00} >= s2_sat_rhs_reg);
        end
        if (sel_red) begin
            cls_next = hsvc_pkg::CLS_RED;
        end else if (sel_blue) begin
            cls_next = hsvc_pkg::CLS_BLUE;
        end else if (sel_grn && sat_gt) begin
            cls_next = hsvc_pkg::CLS_GREEN;
        end else begin
            cls_next = hsvc_pkg::CLS_NONE;
        end
        entry_next.pix_out = (cls_next != hsvc_pkg::CLS_NONE) ? s2_pix_reg : '0;
        entry_next.cls     = cls_next;
        entry_next.mx      = s2_mx_reg;
        entry_next.chroma  = s2_chroma_reg;
        entry_next.p       = s2_p_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pix_reg     <= s_tdata;
            s1_mx_reg      <= mx_next;
            s1_chroma_reg  <= mx_next - mn_next;
            s1_red_max_reg <= red_max_next;
            s1_grn_max_reg <= grn_max_next;

            s2_pix_reg     <= s1_pix_reg;
            s2_mx_reg      <= s1_mx_reg;
            s2_chroma_reg  <= s1_chroma_reg;
            s2_p_reg       <= p_next;
            s2_rl_reg      <= 17'(cfg.red_low_limit) * 17'(s1_chroma_reg);
            s2_rh_reg      <= 17'(cfg.red_high_limit) * 17'(s1_chroma_reg);
            s2_bl_reg      <= 17'(cfg.blue_low_limit) * 17'(s1_chroma_reg);
            s2_bh_reg      <= 17'(cfg.blue_high_limit) * 17'(s1_chroma_reg);
            s2_gl_reg      <= 17'(cfg.green_low_limit) * 17'(s1_chroma_reg);
            s2_gh_reg      <= 17'(cfg.green_high_limit) * 17'(s1_chroma_reg);
            s2_sat_rhs_reg <= sat_rhs_next;

            s3_entry_reg   <= entry_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hsvc_back.sv
// Back end: pipelined restoring dividers for hue and saturation, output register.
`default_nettype none

module hsvc_back #(
    parameter int unsigned HUE_FRAC_BITS = hsvc_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      q_not_empty,
    input  wire hsvc_pkg::q_entry_t  q_entry,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [63:0]              m_tdata,
    output logic [1:0]               m_tuser
);

    localparam int unsigned Q      = 9 + HUE_FRAC_BITS;   // quotient bits
    localparam int unsigned WW     = Q + 8;               // remainder + quotient
    localparam int unsigned STEP   = hsvc_pkg::DIV_BITS_PER_STG;
    localparam int unsigned NSTAGE = (Q + STEP - 1) / STEP;

    // Up to STEP restoring steps; w holds {remainder, numerator/quotient bits}.
    function automatic logic [WW-1:0] div_steps(input logic [WW-1:0] w,
                                                input logic [7:0] d,
                                                input int unsigned n);
        logic [8:0]   t;
        logic [7:0]   rem;
        logic [Q-1:0] low;
        logic         qbit;
        rem = w[WW-1:Q];
        low = w[Q-1:0];
        for (int j = 0; j < STEP; j++) begin
            if (j < n) begin
                t    = {rem, low[Q-1]};
                qbit = (t >= {1'b0, d});
                if (qbit) begin
                    t = t - {1'b0, d};
                end
                rem = t[7:0];
                low = {low[Q-2:0], qbit};
            end
        end
        return {rem, low};
    endfunction

    logic adv;

    logic                stg_valid_reg [NSTAGE];
    logic [WW-1:0]       stg_wh_reg    [NSTAGE];
    logic [WW-1:0]       stg_ws_reg    [NSTAGE];
    hsvc_pkg::back_pay_t stg_pay_reg   [NSTAGE];

    logic        out_valid_reg;
    logic [14:0] out_hue_reg, hue_next;
    logic [8:0]  out_sat_reg, sat_next;
    logic [7:0]  out_bright_reg;
    logic [1:0]  out_cls_reg;
    logic [31:0] out_pix_reg;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_not_empty;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stg
        localparam int unsigned NS = ((Q - k * STEP) < STEP) ? (Q - k * STEP) : STEP;
        logic                v_in;
        logic [WW-1:0]       wh_in, ws_in, wh_next, ws_next;
        hsvc_pkg::back_pay_t pay_in;

        if (k == 0) begin : g_head
            always_comb begin
                v_in           = q_pop;
                wh_in          = WW'(q_entry.p) << HUE_FRAC_BITS;
                ws_in          = WW'(q_entry.chroma) << hsvc_pkg::SAT_SHIFT;
                pay_in.pix_out = q_entry.pix_out;
                pay_in.cls     = q_entry.cls;
                pay_in.mx      = q_entry.mx;
                pay_in.chroma  = q_entry.chroma;
            end
        end else begin : g_body
            always_comb begin
                v_in   = stg_valid_reg[k-1];
                wh_in  = stg_wh_reg[k-1];
                ws_in  = stg_ws_reg[k-1];
                pay_in = stg_pay_reg[k-1];
            end
        end

        assign wh_next = div_steps(wh_in, pay_in.chroma, NS);
        assign ws_next = div_steps(ws_in, pay_in.mx, NS);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                stg_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_wh_reg[k]  <= wh_next;
                stg_ws_reg[k]  <= ws_next;
                stg_pay_reg[k] <= pay_in;
            end
        end
    end

    // Zero chroma: hue 0, saturation 256 (the hue divider ran on a zero divisor).
    always_comb begin
        if (stg_pay_reg[NSTAGE-1].chroma == '0) begin
            hue_next = '0;
            sat_next = hsvc_pkg::SAT_GREY;
        end else begin
            hue_next = 15'(stg_wh_reg[NSTAGE-1][Q-1:0]);
            sat_next = 9'(stg_ws_reg[NSTAGE-1][Q-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= stg_valid_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hue_reg    <= hue_next;
            out_sat_reg    <= sat_next;
            out_bright_reg <= stg_pay_reg[NSTAGE-1].mx;
            out_cls_reg    <= stg_pay_reg[NSTAGE-1].cls;
            out_pix_reg    <= stg_pay_reg[NSTAGE-1].pix_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg, out_bright_reg, out_sat_reg, out_hue_reg};
    assign m_tuser  = out_cls_reg;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the HSV hue colour classifier core.
`default_nettype none

module tb_top;

    // Hue fraction width used by both the instance and the predictor.
    localparam int unsigned HUE_FRAC     = hsvc_pkg::HUE_FRAC_BITS_DEF;
    // Index just past green_sat_floor; the block must drop writes to it.
    localparam logic [2:0]  REG_NONE     = 3'd7;
    // Idle clocks added after the last result so the pipeline is flushed.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    // Receiver hold-off: starts once this many results are in, lasts this long.
    localparam int unsigned HOLD_AT      = 200;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned PHASE_PIXELS = 115;

    // Expected result of one pixel, in the order of the result fields.
    typedef struct packed {
        logic [14:0] hue;
        logic [8:0]  sat;
        logic [7:0]  bright;
        logic [1:0]  cls;
        logic [31:0] pix;
    } hsv_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = hsvc_pkg::REG_RED_LOW;
    logic [8:0]  cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         cfg_ready;

    hsv_hue_color_classifier_core #(
        .HUE_FRAC_BITS(HUE_FRAC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the band registers, updated as each write request is taken.
    hsvc_pkg::cfg_t band_cfg;
    logic [31:0]   pixel_backlog[$];     // pixels not yet offered
    hsv_result_t   expected_results[$];  // one entry per accepted pixel
    int unsigned   mismatches  = 0;
    int unsigned   res_count   = 0;
    int unsigned   cycle_count = 0;
    bit            pix_took    = 1'b0;   // input request taken at the last edge
    bit            tx_idle_on  = 1'b1;
    bit            rx_idle_on  = 1'b1;
    int unsigned   tx_gap      = 0;
    int unsigned   rx_gap      = 0;
    int unsigned   hold_left   = 0;
    bit            hold_done   = 1'b0;

    always #1 aclk = ~aclk;

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Random pixel, biased toward ties, greys, tiny channels (exact band
    // edges) and strong greens so every class and hue branch gets traffic.
    function automatic logic [31:0] random_pixel();
        logic [7:0]  r, g, b, a;
        int unsigned kind;
        a = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        kind = $urandom_range(0, 9);
        case (kind)
            4: begin
                g = r;
                b = r;
            end
            5: g = r;
            6: b = g;
            7: b = r;
            8: begin
                r = 8'($urandom_range(0, 7));
                g = 8'($urandom_range(0, 7));
                b = 8'($urandom_range(0, 7));
            end
            9: begin
                g = 8'($urandom_range(200, 255));
                r = 8'($urandom_range(0, 32'(g)));
                b = 8'($urandom_range(0, 32'(g)));
            end
            default: ;
        endcase
        return {a, b, g, r};
    endfunction

    // Predictor: HSV conversion and band classification of one pixel. Hue is
    // carried as p = degrees * chroma so band tests stay exact.
    function automatic hsv_result_t classify_pixel(input logic [31:0] pix);
        int unsigned r, g, b, mx, mn, c, sat, p, hue;
        bit          in_red, in_blue, in_green;
        hsv_result_t res;
        r  = 32'(pix[7:0]);
        g  = 32'(pix[15:8]);
        b  = 32'(pix[23:16]);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        c  = mx - mn;
        p  = 0;
        hue = 0;
        if (c == 0) begin
            sat = 256;
        end else begin
            sat = (c * 256) / mx;
            // red wins ties, then green
            if (mx == r) begin
                if (g >= b)
                    p = 60 * (g - b);
                else
                    p = 360 * c - 60 * (b - g);
            end else if (mx == g) begin
                p = 120 * c + 60 * b - 60 * r;
            end else begin
                p = 240 * c + 60 * r - 60 * g;
            end
            hue = (p << HUE_FRAC) / c;
        end
        in_red   = (p <= 32'(band_cfg.red_low_limit) * c)
                || (p >= 32'(band_cfg.red_high_limit) * c);
        in_blue  = (p >= 32'(band_cfg.blue_low_limit) * c)
                && (p <= 32'(band_cfg.blue_high_limit) * c);
        in_green = (p >= 32'(band_cfg.green_low_limit) * c)
                && (p <= 32'(band_cfg.green_high_limit) * c);
        if (in_red)
            res.cls = hsvc_pkg::CLS_RED;
        else if (in_blue)
            res.cls = hsvc_pkg::CLS_BLUE;
        else if (in_green && sat > 32'(band_cfg.green_sat_floor))
            res.cls = hsvc_pkg::CLS_GREEN;
        else
            res.cls = hsvc_pkg::CLS_NONE;
        res.hue    = hue[14:0];
        res.sat    = sat[8:0];
        res.bright = mx[7:0];
        res.pix    = (res.cls != hsvc_pkg::CLS_NONE) ? pix : 32'h0;
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // One register write request; the mirror follows once it is taken.
    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            hsvc_pkg::REG_RED_LOW:   band_cfg.red_low_limit    = val;
            hsvc_pkg::REG_RED_HIGH:  band_cfg.red_high_limit   = val;
            hsvc_pkg::REG_BLUE_LOW:  band_cfg.blue_low_limit   = val;
            hsvc_pkg::REG_BLUE_HIGH: band_cfg.blue_high_limit  = val;
            hsvc_pkg::REG_GRN_LOW:   band_cfg.green_low_limit  = val;
            hsvc_pkg::REG_GRN_HIGH:  band_cfg.green_high_limit = val;
            hsvc_pkg::REG_GRN_SAT:   band_cfg.green_sat_floor  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Rewrite the whole bank, plus a write to the unused index that must be dropped.
    task automatic set_bands(input logic [8:0] rl, input logic [8:0] rh,
                             input logic [8:0] bl, input logic [8:0] bh,
                             input logic [8:0] gl, input logic [8:0] gh,
                             input logic [8:0] gs);
        write_reg(REG_NONE, 9'($urandom_range(0, 511)));
        write_reg(hsvc_pkg::REG_RED_LOW, rl);
        write_reg(hsvc_pkg::REG_RED_HIGH, rh);
        write_reg(hsvc_pkg::REG_BLUE_LOW, bl);
        write_reg(hsvc_pkg::REG_BLUE_HIGH, bh);
        write_reg(hsvc_pkg::REG_GRN_LOW, gl);
        write_reg(hsvc_pkg::REG_GRN_HIGH, gh);
        write_reg(hsvc_pkg::REG_GRN_SAT, gs);
    endtask

    // Sender pause: everything offered, taken and checked, then pipeline flush.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pixel_backlog.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Pixel driver: holds a request until taken, then gap or next pixel.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !pix_took) begin
            // request still pending
        end else if (tx_gap != 0) begin
            s_tvalid <= 1'b0;
            tx_gap = tx_gap - 1;
        end else if (pixel_backlog.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pixel_backlog.pop_front();
            if (tx_idle_on)
                tx_gap = pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off that lets the
    // internal queue fill and push back on s_tready.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && res_count >= HOLD_AT) begin
            m_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_on)
                rx_gap = pick_gap();
        end
    end

    // Monitor: predict on each accepted pixel, check each accepted result.
    always @(posedge aclk) begin : result_check
        hsv_result_t want;
        pix_took = aresetn && s_tvalid && s_tready;
        if (pix_took)
            expected_results = {expected_results, classify_pixel(s_tdata)};
        if (aresetn && m_tvalid && m_tready) begin
            res_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no pixel pending, expected none, %s %h user %h",
                         $time, "got tdata", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("hue", 32'(want.hue), 32'(m_tdata[14:0]));
                check_field("saturation", 32'(want.sat), 32'(m_tdata[23:15]));
                check_field("brightness", 32'(want.bright), 32'(m_tdata[31:24]));
                check_field("pixel_out", want.pix, m_tdata[63:32]);
                check_field("color_class", 32'(want.cls), 32'(m_tuser));
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus sequence: directed corners and random pixels at reset settings,
    // then phases of random pixels, each under a new register setting written while idle.
    initial begin
        band_cfg.red_low_limit    = 9'd35;
        band_cfg.red_high_limit   = 9'd330;
        band_cfg.blue_low_limit   = 9'd120;
        band_cfg.blue_high_limit  = 9'd320;
        band_cfg.green_low_limit  = 9'd50;
        band_cfg.green_high_limit = 9'd120;
        band_cfg.green_sat_floor  = 9'd153;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        pixel_backlog = {
            32'h00000000,   // black: grey, hue 0, saturation 256
            32'hFFFFFFFF,   // white with full alpha
            32'h5A808080,   // mid grey
            32'h000000FF,   // pure red
            32'h0000FF00,   // pure green, hue 120 on the blue band edge
            32'h00FF0000,   // pure blue
            32'h0000FFFF,   // red/green tie: red wins
            32'h00FFFF00,   // green/blue tie: green wins
            32'h00FF00FF,   // red/blue tie: red wins
            32'h0000070C,   // hue exactly 35
            32'h000095FF,   // hue just above 35
            32'h00010002,   // hue exactly 330
            32'h00020003,   // hue exactly 320
            32'h00000506,   // hue exactly 50
            32'h00000203,   // hue 40, between bands
            32'h0000C864,   // saturated green
            32'h0064C896,   // green hue, saturation too low
            32'h0066FFB2,   // saturation exactly at the green floor
            32'h0065FFB2,   // saturation one above the green floor
            32'hA5400080,   // red max with blue above green: wraps past 300
            32'h00FE0001,   // blue max, red above green
            32'h80010000    // faint blue, alpha top bit set
        };
        repeat (100) pixel_backlog = {pixel_backlog, random_pixel()};
        wait_drained();

        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: set_bands(9'($urandom_range(0, 359)), 9'($urandom_range(0, 359)),
                             9'($urandom_range(0, 359)), 9'($urandom_range(0, 359)),
                             9'($urandom_range(0, 359)), 9'($urandom_range(0, 359)),
                             9'($urandom_range(0, 256)));
                // red only at hue 0, blue band empty, green floor unreachable
                2: set_bands(9'd0, 9'd511, 9'd511, 9'd0, 9'd0, 9'd511, 9'd256);
                // nearly everything blue
                3: set_bands(9'd0, 9'd360, 9'd0, 9'd359, 9'd0, 9'd0, 9'd0);
                // blue empty, red only at hue 0, green takes coloured pixels up to hue 359
                4: set_bands(9'd0, 9'd511, 9'd300, 9'd200, 9'd0, 9'd359, 9'd0);
                default: set_bands(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                   9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                   9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                   9'($urandom_range(0, 511)));
            endcase
            // phase 3 runs flat out on both sides
            tx_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_PIXELS) pixel_backlog = {pixel_backlog, random_pixel()};
            wait_drained();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
